### rtl/ptt_pkg.sv
package ptt_pkg;

    localparam int EDGES   = 32;
    localparam int SLOT_W  = $clog2(EDGES);
    localparam int STATE_W = 4;
    localparam int SYM_W   = 4;
    localparam int ACT_W   = 8;
    localparam int NUM_W   = 5;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'd1;

    localparam logic [NUM_W-1:0]   NUM_STATES_RST  = 5'd16;
    localparam logic [STATE_W-1:0] START_STATE_RST = 4'd0;

    typedef struct packed {
        logic [STATE_W-1:0] src;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] sink;
        logic [ACT_W-1:0]   act;
    } edge_t;

    typedef struct packed {
        logic              load_we;
        logic              restart;
        logic              step_start;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              finish;
        logic              found;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic out_free;
    } stat_t;

endpackage

### rtl/ptt_in_if.sv
interface ptt_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::OP_W-1:0]      action;
    logic [ptt_pkg::SLOT_W-1:0]    edge_slot;
    logic                          edge_valid;
    logic [ptt_pkg::STATE_W-1:0]   edge_source;
    logic [ptt_pkg::SYM_W-1:0]     edge_symbol;
    logic [ptt_pkg::STATE_W-1:0]   edge_sink;
    logic [ptt_pkg::ACT_W-1:0]     edge_action;
    logic [ptt_pkg::SYM_W-1:0]     symbol;

    modport source (
        output valid, action, edge_slot, edge_valid, edge_source, edge_symbol,
               edge_sink, edge_action, symbol,
        input  ready
    );

    modport sink (
        input  valid, action, edge_slot, edge_valid, edge_source, edge_symbol,
               edge_sink, edge_action, symbol,
        output ready
    );
endinterface

### rtl/ptt_out_if.sv
interface ptt_out_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::ACT_W-1:0]     fired_action;
    logic [ptt_pkg::SYM_W-1:0]     seen_symbol;
    logic                          no_match;
    logic [ptt_pkg::STATE_W-1:0]   state_after;

    modport source (
        output valid, fired_action, seen_symbol, no_match, state_after,
        input  ready
    );

    modport sink (
        input  valid, fired_action, seen_symbol, no_match, state_after,
        output ready
    );
endinterface

### rtl/ptt_ctrl.sv
module ptt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [ptt_pkg::OP_W-1:0] item_action,
    output logic                     item_ready,
    input  ptt_pkg::stat_t           stat,
    output ptt_pkg::cmd_t            cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [ptt_pkg::SLOT_W:0]   idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic                       found_reg, found_next;
    logic                       accept;
    logic                       scan_hit;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    // compare result is only meaningful in the cycle after a read
    assign scan_hit   = pend_reg && stat.hit;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        cmd.load_we    = accept && (item_action == ptt_pkg::OP_LOAD);
        cmd.restart    = accept && (item_action == ptt_pkg::OP_RESTART);
        cmd.step_start = accept && (item_action == ptt_pkg::OP_STEP);
        cmd.rd_addr    = idx_reg[ptt_pkg::SLOT_W-1:0];
        cmd.found      = found_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.step_start)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en  = !idx_reg[ptt_pkg::SLOT_W] && !scan_hit;
                pend_next  = cmd.rd_en;
                if (cmd.rd_en)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (scan_hit)
                begin
                    state_next = ST_DONE;
                    found_next = 1'b1;
                end
                else if (idx_reg[ptt_pkg::SLOT_W])
                begin
                    state_next = ST_DONE;
                    found_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                cmd.finish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

endmodule

### rtl/ptt_dp.sv
module ptt_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptt_pkg::cmd_t                 cmd,
    output ptt_pkg::stat_t                stat,
    input  logic                          cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_data,
    input  logic [ptt_pkg::SLOT_W-1:0]    edge_slot,
    input  logic                          edge_valid,
    input  logic [ptt_pkg::STATE_W-1:0]   edge_source,
    input  logic [ptt_pkg::SYM_W-1:0]     edge_symbol,
    input  logic [ptt_pkg::STATE_W-1:0]   edge_sink,
    input  logic [ptt_pkg::ACT_W-1:0]     edge_action,
    input  logic [ptt_pkg::SYM_W-1:0]     symbol,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [ptt_pkg::ACT_W-1:0]     fired_action,
    output logic [ptt_pkg::SYM_W-1:0]     seen_symbol,
    output logic                          no_match,
    output logic [ptt_pkg::STATE_W-1:0]   state_after
);

    ptt_pkg::edge_t                  edge_mem_reg [ptt_pkg::EDGES];
    logic [ptt_pkg::EDGES-1:0]       valid_reg;
    ptt_pkg::edge_t                  rd_data_reg;
    logic                            rd_valid_reg;
    logic [ptt_pkg::NUM_W-1:0]       num_states_reg;
    logic [ptt_pkg::STATE_W-1:0]     start_state_reg;
    logic [ptt_pkg::STATE_W-1:0]     cur_state_reg, cur_state_next;
    logic [ptt_pkg::SYM_W-1:0]       sym_reg;
    logic                            out_valid_reg;
    logic [ptt_pkg::ACT_W-1:0]       fired_action_reg;
    logic [ptt_pkg::SYM_W-1:0]       seen_symbol_reg;
    logic                            no_match_reg;
    logic [ptt_pkg::STATE_W-1:0]     state_after_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            edge_mem_reg[edge_slot] <= '{src: edge_source, sym: edge_symbol,
                                         sink: edge_sink, act: edge_action};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg  <= edge_mem_reg[cmd.rd_addr];
            rd_valid_reg <= valid_reg[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.load_we)
        begin
            valid_reg[edge_slot] <= edge_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg  <= ptt_pkg::NUM_STATES_RST;
            start_state_reg <= ptt_pkg::START_STATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptt_pkg::CFG_NUM_STATES:
                begin
                    num_states_reg <= cfg_data[ptt_pkg::NUM_W-1:0];
                end
                ptt_pkg::CFG_START_STATE:
                begin
                    start_state_reg <= cfg_data[ptt_pkg::STATE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.hit = rd_valid_reg
                      && (rd_data_reg.src == cur_state_reg)
                      && (rd_data_reg.sym == sym_reg);
    assign stat.out_free = !out_valid_reg || result_ready;

    // sink at or above num_states leaves the machine where it is
    always_comb
    begin
        cur_state_next = cur_state_reg;
        if (cmd.found && ({1'b0, rd_data_reg.sink} < num_states_reg))
        begin
            cur_state_next = rd_data_reg.sink;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg <= ptt_pkg::START_STATE_RST;
        end
        else if (cmd.restart)
        begin
            cur_state_reg <= start_state_reg;
        end
        else if (cmd.finish)
        begin
            cur_state_reg <= cur_state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_start)
        begin
            sym_reg <= symbol;
        end
        if (cmd.finish)
        begin
            fired_action_reg <= cmd.found ? rd_data_reg.act : '0;
            seen_symbol_reg  <= sym_reg;
            no_match_reg     <= !cmd.found;
            state_after_reg  <= cur_state_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign fired_action = fired_action_reg;
    assign seen_symbol  = seen_symbol_reg;
    assign no_match     = no_match_reg;
    assign state_after  = state_after_reg;

endmodule

### rtl/programmable_transition_table_fsm.sv
// Load and restart transactions: one cycle each, next transaction taken the cycle after.
// Step transactions: result valid after the scan ends and the result is registered; the edge table is scanned
// one slot per cycle through a registered memory read, stopping at the first hit. A step
// waits in its last cycle while the previous result is still held; input reopens after it.
// Reset (rst_n, async active low): all edges invalid, state 0, num_states 16,
// start_state 0; ready is high in reset, first transaction taken at the first edge after.
module programmable_transition_table_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_data,
    ptt_in_if.sink                        item,
    ptt_out_if.source                     result
);

    ptt_pkg::cmd_t  cmd;
    ptt_pkg::stat_t stat;

    ptt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    ptt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .edge_slot    (item.edge_slot),
        .edge_valid   (item.edge_valid),
        .edge_source  (item.edge_source),
        .edge_symbol  (item.edge_symbol),
        .edge_sink    (item.edge_sink),
        .edge_action  (item.edge_action),
        .symbol       (item.symbol),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .fired_action (result.fired_action),
        .seen_symbol  (result.seen_symbol),
        .no_match     (result.no_match),
        .state_after  (result.state_after)
    );

endmodule

### rtl/ptt_checker.sv
module ptt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic [ptt_pkg::OP_W-1:0]    item_action,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [ptt_pkg::ACT_W-1:0]   fired_action,
    input logic                        no_match,
    input logic [ptt_pkg::STATE_W-1:0] state_after
);

    logic item_fire;
    assign item_fire = item_valid && item_ready;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(fired_action) && $stable(no_match)
            && $stable(state_after))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_match |-> fired_action == '0)
        else $error("no_match result carries an action code");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (item_action == ptt_pkg::OP_STEP) |=> !item_ready)
        else $error("ready during step scan");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (item_action != ptt_pkg::OP_STEP) && !result_valid
            |=> !result_valid)
        else $error("result from a non-step transaction");

endmodule

bind programmable_transition_table_fsm ptt_checker u_ptt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_action  (item.action),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .fired_action (result.fired_action),
    .no_match     (result.no_match),
    .state_after  (result.state_after)
);
